[rtl/rocca_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rocca_pkg
// Shared types, constants and AES round function for the Rocca encryptor.
// ----------------------------------------------------------------------------
package rocca_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned LaneW  = 128;
  localparam int unsigned Lanes  = 8;
  localparam int unsigned Rounds = 20;
  localparam int unsigned RndW   = 5;

  typedef logic [LaneW-1:0] lane_t;
  typedef lane_t [Lanes-1:0] lanes_t;

  typedef enum logic [1:0] {
    REQ_INIT = 2'd0,
    REQ_AD   = 2'd1,
    REQ_MSG  = 2'd2,
    REQ_FIN  = 2'd3
  } req_t;

  localparam logic OUT_CT  = 1'b0;
  localparam logic OUT_TAG = 1'b1;

  localparam lane_t Z0 = {64'h428a2f98d728ae22, 64'h7137449123ef65cd};
  localparam lane_t Z1 = {64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOP,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;    // latch request, run single round or load init lanes
    logic loop_step;  // one round of the 20-round loop
    logic loop_done;  // commit loop result
  } dp_cmd_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a lane sits at bits 8i+7:8i
  function automatic lane_t aes_round(input lane_t s, input lane_t k);
    logic [7:0] sr [16];
    logic [7:0] a0, a1, a2, a3, t;
    lane_t res;
    res = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[r + 4*c] = Sbox[s[8*(r + 4*((c + r) & 3)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sr[4*c]; a1 = sr[4*c+1]; a2 = sr[4*c+2]; a3 = sr[4*c+3];
      t = a0 ^ a1 ^ a2 ^ a3;
      res[8*(4*c)   +: 8] = a0 ^ t ^ xt(a0 ^ a1);
      res[8*(4*c+1) +: 8] = a1 ^ t ^ xt(a1 ^ a2);
      res[8*(4*c+2) +: 8] = a2 ^ t ^ xt(a2 ^ a3);
      res[8*(4*c+3) +: 8] = a3 ^ t ^ xt(a3 ^ a0);
    end
    return res ^ k;
  endfunction

  function automatic lanes_t update(input lanes_t s, input lane_t x0, input lane_t x1);
    lanes_t n;
    n[7] = s[6] ^ s[0];
    n[6] = aes_round(s[5], s[4]);
    n[5] = aes_round(s[4], s[3]);
    n[4] = s[3] ^ x1;
    n[3] = aes_round(s[2], s[1]);
    n[2] = s[1] ^ s[6];
    n[1] = aes_round(s[0], s[7]);
    n[0] = s[7] ^ x0;
    return n;
  endfunction

endpackage

[rtl/rocca_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rocca_in_if / rocca_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface rocca_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] data_w0;
  logic [63:0] data_w1;
  logic [63:0] data_w2;
  logic [63:0] data_w3;
  modport source (output valid, req_type, data_w0, data_w1, data_w2, data_w3, input ready);
  modport sink (input valid, req_type, data_w0, data_w1, data_w2, data_w3, output ready);
endinterface

interface rocca_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [63:0] out_w0;
  logic [63:0] out_w1;
  logic [63:0] out_w2;
  logic [63:0] out_w3;
  modport source (output valid, out_kind, out_w0, out_w1, out_w2, out_w3, input ready);
  modport sink (input valid, out_kind, out_w0, out_w1, out_w2, out_w3, output ready);
endinterface

[rtl/rocca_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rocca_ctrl
// Request sequencer: accepts a request, counts loop rounds, hands off results.
// ----------------------------------------------------------------------------
module rocca_ctrl
  import rocca_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_type,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic [RndW-1:0] rnd_r, rnd_nxt;
  logic [1:0] in_type_r;
  logic acc, last;

  assign acc  = in_valid && in_ready;
  assign last = (rnd_r == RndW'(Rounds - 1));

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          rnd_nxt = '0;
          case (in_type)
            REQ_INIT, REQ_FIN: state_nxt = ST_LOOP;
            REQ_MSG:           state_nxt = ST_OUT;
            default:           state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOOP: begin
        rnd_nxt = rnd_r + 1'b1;
        if (last) begin
          state_nxt = (in_type_r == REQ_FIN) ? ST_OUT : ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc) in_type_r <= in_type;
  end

  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    out_valid      = (state_r == ST_OUT);
    cmd.load_in    = acc;
    cmd.loop_step  = (state_r == ST_LOOP);
    cmd.loop_done  = (state_r == ST_LOOP) && last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

endmodule

[rtl/rocca_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rocca_dp
// Lane state, length counters, round unit, keystream and tag logic.
// ----------------------------------------------------------------------------
module rocca_dp
  import rocca_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  dp_cmd_t      cmd,
  input  logic [1:0]   in_type,
  input  logic [255:0] in_data,
  input  logic [255:0] key,
  output logic         res_kind,
  output logic [255:0] res_data
);

  lanes_t lanes_r, work_r, lanes_nxt, work_nxt;
  logic [63:0] ad_len_r, msg_len_r;
  logic [1:0] type_r;
  logic res_kind_r;
  logic [255:0] res_r;
  lane_t p0, p1, k0, k1, x0, x1, tag;
  lanes_t upd_in, upd_out, init_l;

  assign p0 = in_data[127:0];
  assign p1 = in_data[255:128];

  always_comb begin
    init_l[0] = key[255:128];
    init_l[1] = p0;
    init_l[2] = Z0;
    init_l[3] = Z1;
    init_l[4] = p0 ^ key[255:128];
    init_l[5] = '0;
    init_l[6] = key[127:0];
    init_l[7] = '0;
  end

  // single shared round unit: input block, or loop constants / finalize lengths
  always_comb begin
    if (cmd.loop_step) begin
      upd_in = work_r;
      if (type_r == REQ_FIN) begin
        x0 = {64'd0, ad_len_r};
        x1 = {64'd0, msg_len_r};
      end else begin
        x0 = Z0;
        x1 = Z1;
      end
    end else begin
      upd_in = lanes_r;
      x0 = p0;
      x1 = p1;
    end
  end
  assign upd_out = update(upd_in, x0, x1);

  assign k0 = aes_round(lanes_r[1], lanes_r[5]);
  assign k1 = aes_round(lanes_r[0] ^ lanes_r[4], lanes_r[2]);

  always_comb begin
    tag = '0;
    for (int i = 0; i < Lanes; i++) tag = tag ^ upd_out[i];
  end

  always_comb begin
    lanes_nxt = lanes_r;
    work_nxt  = work_r;
    if (cmd.load_in) begin
      case (in_type)
        REQ_INIT: work_nxt = init_l;
        REQ_FIN:  work_nxt = lanes_r;
        default:  lanes_nxt = upd_out;
      endcase
    end else if (cmd.loop_step) begin
      work_nxt = upd_out;
      if (cmd.loop_done && type_r == REQ_INIT) lanes_nxt = upd_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lanes_r  <= '0;
      ad_len_r <= '0;
      msg_len_r <= '0;
    end else begin
      lanes_r <= lanes_nxt;
      if (cmd.load_in && in_type == REQ_AD)  ad_len_r  <= ad_len_r + 64'd256;
      if (cmd.load_in && in_type == REQ_MSG) msg_len_r <= msg_len_r + 64'd256;
      if (cmd.loop_done && type_r == REQ_INIT) begin
        ad_len_r  <= '0;
        msg_len_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    if (cmd.load_in) begin
      type_r <= in_type;
      if (in_type == REQ_MSG) begin
        res_kind_r <= OUT_CT;
        res_r <= {p1 ^ k1, p0 ^ k0};
      end
    end
    if (cmd.loop_done) begin
      res_kind_r <= OUT_TAG;
      res_r <= {128'd0, tag};
    end
  end

  assign res_kind = res_kind_r;
  assign res_data = res_r;

endmodule

[rtl/rocca_aead_encrypt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rocca_aead_encrypt
// Rocca encryptor top level: key registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// Associated-data blocks are absorbed as they are accepted; a message block is
// absorbed too and its ciphertext waits in the output register until taken.
// Init and finalize make 20 passes through the single round unit (four AES
// rounds in parallel), finalize then hands off the tag. One request is worked
// on at a time. Keys are to be written on cfg_* while idle (not enforced).
module rocca_aead_encrypt
  import rocca_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  rocca_in_if.sink    in_if,
  rocca_out_if.source out_if
);

  logic [63:0] key_r [4];
  dp_cmd_t cmd;
  logic [255:0] res_data;
  logic res_kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  rocca_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_if.valid),
    .in_type  (in_if.req_type),
    .in_ready (in_if.ready),
    .out_valid(out_if.valid),
    .out_ready(out_if.ready),
    .cmd
  );

  rocca_dp u_dp (
    .clk, .rst_n, .cmd,
    .in_type (in_if.req_type),
    .in_data ({in_if.data_w3, in_if.data_w2, in_if.data_w1, in_if.data_w0}),
    .key     ({key_r[3], key_r[2], key_r[1], key_r[0]}),
    .res_kind,
    .res_data
  );

  assign out_if.out_kind = res_kind;
  assign out_if.out_w0 = res_data[63:0];
  assign out_if.out_w1 = res_data[127:64];
  assign out_if.out_w2 = res_data[191:128];
  assign out_if.out_w3 = res_data[255:192];

endmodule

[rtl/rocca_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rocca_chk
// Port-level checks on the Rocca encryptor, bound to the top level.
// ----------------------------------------------------------------------------
module rocca_chk
  import rocca_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [63:0] out_w2,
  input logic [63:0] out_w3
);

  a_tag_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == OUT_TAG |-> out_w2 == '0 && out_w3 == '0)
    else $error("tag upper words not zero");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input open while result pending");

  a_ad_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_type == REQ_AD |=> !out_valid && in_ready)
    else $error("associated data produced a result");

  a_msg_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_type == REQ_MSG |=> out_valid && out_kind == OUT_CT)
    else $error("message block gave no ciphertext");

  // a stalled result stays put until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_w2)
    && $stable(out_w3))
    else $error("result changed while stalled");

endmodule

bind rocca_aead_encrypt rocca_chk u_chk (
  .clk, .rst_n,
  .in_valid (in_if.valid),
  .in_ready (in_if.ready),
  .in_type  (in_if.req_type),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_kind (out_if.out_kind),
  .out_w2   (out_if.out_w2),
  .out_w3   (out_if.out_w3)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the Rocca encryptor against its own lane-state predictor. A short
// stimulus table covers reset state, extremes and every request kind, then
// random init / associated-data / message / finalize sessions follow under
// several keys, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import rocca_pkg::*;

  localparam int unsigned Limit = 20000;

  typedef struct {
    logic        kind;
    logic [63:0] w0, w1, w2, w3;
  } ct_res_t;

  typedef struct {
    req_t        rq;
    logic [63:0] d0, d1, d2, d3;
    bit          has_gold;
    logic [63:0] g0, g1;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;

  rocca_in_if  in_ch();
  rocca_out_if out_ch();

  rocca_aead_encrypt u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch.sink),
    .out_if    (out_ch.source)
  );

  // predictor state
  logic [63:0] key_q [4];
  logic [127:0] st_lane [8];
  logic [63:0] ad_bits, msg_bits;

  ct_res_t pending_q [$];
  int      err_cnt;
  int      idle_cycles;
  int      rx_wait;
  bit      rx_hold;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // table lookup and mix done independently of the package helpers
  function automatic logic [7:0] gmul2(input logic [7:0] b);
    gmul2 = (b << 1) ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_rnd(input logic [127:0] s, input logic [127:0] k);
    logic [7:0] sb [16];
    logic [127:0] r;
    logic [7:0] b0, b1, b2, b3, x;
    for (int c = 0; c < 4; c++)
      for (int j = 0; j < 4; j++)
        sb[4*c + j] = Sbox[s[8*(j + 4*((c + j) % 4)) +: 8]];
    for (int c = 0; c < 4; c++) begin
      b0 = sb[4*c]; b1 = sb[4*c+1]; b2 = sb[4*c+2]; b3 = sb[4*c+3];
      x = b0 ^ b1 ^ b2 ^ b3;
      r[32*c +: 8]      = b0 ^ x ^ gmul2(b0 ^ b1);
      r[32*c + 8 +: 8]  = b1 ^ x ^ gmul2(b1 ^ b2);
      r[32*c + 16 +: 8] = b2 ^ x ^ gmul2(b2 ^ b3);
      r[32*c + 24 +: 8] = b3 ^ x ^ gmul2(b3 ^ b0);
    end
    return r ^ k;
  endfunction

  task automatic rocca_round(inout logic [127:0] s [8], input logic [127:0] x0,
                             input logic [127:0] x1);
    logic [127:0] n [8];
    n[7] = s[6] ^ s[0];
    n[6] = aes_rnd(s[5], s[4]);
    n[5] = aes_rnd(s[4], s[3]);
    n[4] = s[3] ^ x1;
    n[3] = aes_rnd(s[2], s[1]);
    n[2] = s[1] ^ s[6];
    n[1] = aes_rnd(s[0], s[7]);
    n[0] = s[7] ^ x0;
    s = n;
  endtask

  // advance lanes for one request (finalize works on a copy); has_out is 1 with a result when one is due
  task automatic rocca_predict(input req_t rq, input logic [63:0] d0, d1, d2, d3,
                               output bit has_out, output ct_res_t res);
    logic [127:0] p0, p1, k0, k1, z0, z1;
    logic [127:0] wk [8];
    logic [127:0] tg;
    p0 = {d1, d0};
    p1 = {d3, d2};
    z0 = {64'h428a2f98d728ae22, 64'h7137449123ef65cd};
    z1 = {64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc};
    has_out = 1'b0;
    res = '{default: '0};
    case (rq)
      REQ_INIT: begin
        st_lane[0] = {key_q[3], key_q[2]};
        st_lane[1] = p0;
        st_lane[2] = z0;
        st_lane[3] = z1;
        st_lane[4] = p0 ^ {key_q[3], key_q[2]};
        st_lane[5] = '0;
        st_lane[6] = {key_q[1], key_q[0]};
        st_lane[7] = '0;
        for (int i = 0; i < 20; i++) rocca_round(st_lane, z0, z1);
        ad_bits = '0;
        msg_bits = '0;
      end
      REQ_AD: begin
        rocca_round(st_lane, p0, p1);
        ad_bits += 64'd256;
      end
      REQ_MSG: begin
        k0 = aes_rnd(st_lane[1], st_lane[5]);
        k1 = aes_rnd(st_lane[0] ^ st_lane[4], st_lane[2]);
        has_out = 1'b1;
        res.kind = OUT_CT;
        {res.w1, res.w0} = p0 ^ k0;
        {res.w3, res.w2} = p1 ^ k1;
        rocca_round(st_lane, p0, p1);
        msg_bits += 64'd256;
      end
      default: begin
        wk = st_lane;
        for (int i = 0; i < 20; i++) rocca_round(wk, {64'd0, ad_bits}, {64'd0, msg_bits});
        tg = '0;
        foreach (wk[i]) tg ^= wk[i];
        has_out = 1'b1;
        res.kind = OUT_TAG;
        {res.w1, res.w0} = tg;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got, exp_v);
    err_cnt++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
  endtask

  // ---- result side ----
  always @(posedge clk) begin
    ct_res_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected transfer", out_ch.out_w0, '0);
        end else begin
          e = pending_q.pop_front();
          if (out_ch.out_kind !== e.kind) report_mismatch("out_kind", out_ch.out_kind, e.kind);
          if (out_ch.out_w0 !== e.w0) report_mismatch("out_w0", out_ch.out_w0, e.w0);
          if (out_ch.out_w1 !== e.w1) report_mismatch("out_w1", out_ch.out_w1, e.w1);
          if (out_ch.out_w2 !== e.w2) report_mismatch("out_w2", out_ch.out_w2, e.w2);
          if (out_ch.out_w3 !== e.w3) report_mismatch("out_w3", out_ch.out_w3, e.w3);
        end
        // stall drawn per transfer, none while stalls are off
        rx_wait = rx_hold ? int'($urandom_range(0, 16)) : 0;
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_ch.ready <= (rx_wait == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= Limit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---- stimulus side ----
  // valid stays high after a transfer; callers drop it before waiting
  task automatic drive_req(input req_t rq, input logic [63:0] d0, d1, d2, d3,
                           input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= rq;
    in_ch.data_w0  <= d0;
    in_ch.data_w1  <= d1;
    in_ch.data_w2  <= d2;
    in_ch.data_w3  <= d3;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_req(input req_t rq, input logic [63:0] d0, d1, d2, d3,
                          input int gap);
    bit hv;
    ct_res_t r;
    drive_req(rq, d0, d1, d2, d3, gap);
    rocca_predict(rq, d0, d1, d2, d3, hv, r);
    if (hv) pending_q.push_back(r);
  endtask

  task automatic drain_wait();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    // init can still be looping after the last result
    repeat (30) @(posedge clk);
  endtask

  task automatic write_key(input int idx, input logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx[1:0];
    cfg_wdata <= v;
    @(posedge clk);
    key_q[idx] = v;
  endtask

  function automatic logic [63:0] rnd64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    return v;
  endfunction

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  stim_row_t dir_tab [$];

  initial begin
    bit hv;
    ct_res_t r;
    int sent;
    int sess;
    req_t rq;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_INIT;
    in_ch.data_w0 = '0;
    in_ch.data_w1 = '0;
    in_ch.data_w2 = '0;
    in_ch.data_w3 = '0;
    out_ch.ready = 1'b0;
    err_cnt = 0;
    rx_hold = 1'b0;
    foreach (key_q[i]) key_q[i] = '0;
    foreach (st_lane[i]) st_lane[i] = '0;
    ad_bits = '0;
    msg_bits = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-zero state after reset: first ciphertext is aes of zero lanes,
    // which is the sbox constant 0x63 through mixcolumns, i.e. 0x63 bytes
    dir_tab.push_back('{REQ_MSG, '0, '0, '0, '0, 1'b1, 64'h6363636363636363,
                        64'h6363636363636363});
    dir_tab.push_back('{REQ_FIN, '1, '1, '1, '1, 1'b0, '0, '0});
    dir_tab.push_back('{REQ_FIN, '0, '0, '0, '0, 1'b0, '0, '0});
    dir_tab.push_back('{REQ_AD, '1, '1, '1, '1, 1'b0, '0, '0});
    dir_tab.push_back('{REQ_INIT, '0, '0, '1, '1, 1'b0, '0, '0});
    dir_tab.push_back('{REQ_AD, '0, '0, '0, '0, 1'b0, '0, '0});
    dir_tab.push_back('{REQ_MSG, '1, '1, '1, '1, 1'b0, '0, '0});
    dir_tab.push_back('{REQ_MSG, '0, '0, '0, '0, 1'b0, '0, '0});
    dir_tab.push_back('{REQ_FIN, 64'h0123456789abcdef, '0, '0, '0, 1'b0, '0, '0});
    dir_tab.push_back('{REQ_INIT, '1, '1, '0, '0, 1'b0, '0, '0});
    dir_tab.push_back('{REQ_MSG, 64'h8000000000000001, '1, '0, 64'h5555, 1'b0, '0, '0});
    dir_tab.push_back('{REQ_FIN, '0, '0, '0, '0, 1'b0, '0, '0});
    dir_tab.push_back('{REQ_FIN, '0, '0, '0, '0, 1'b0, '0, '0});

    foreach (dir_tab[i]) begin
      if (dir_tab[i].has_gold) begin
        rocca_predict(dir_tab[i].rq, dir_tab[i].d0, dir_tab[i].d1, dir_tab[i].d2,
                      dir_tab[i].d3, hv, r);
        pending_q.push_back('{OUT_CT, dir_tab[i].g0, dir_tab[i].g1, dir_tab[i].g0,
                              dir_tab[i].g1});
        drive_req(dir_tab[i].rq, dir_tab[i].d0, dir_tab[i].d1, dir_tab[i].d2,
                  dir_tab[i].d3, 0);
      end else begin
        send_req(dir_tab[i].rq, dir_tab[i].d0, dir_tab[i].d1, dir_tab[i].d2,
                 dir_tab[i].d3, 0);
      end
    end
    drain_wait();

    // extreme keys, then random keys; stalls switched on after first phase
    sent = 0;
    sess = 0;
    while (sent < 650) begin
      if (sess % 8 == 0) begin
        drain_wait();
        for (int k = 0; k < 4; k++)
          write_key(k, (sess == 0) ? '1 : (sess == 8) ? '0 : rnd64());
        cfg_we <= 1'b0;
        rx_hold = (sess != 0);
      end
      sess++;
      send_req(REQ_INIT, rnd64(), rnd64(), rnd64(), rnd64(), draw_gap());
      sent++;
      repeat ($urandom_range(0, 3)) begin
        send_req(REQ_AD, rnd64(), rnd64(), rnd64(), rnd64(), draw_gap());
        sent++;
      end
      repeat ($urandom_range(0, 8)) begin
        // mostly well-formed, occasionally a stray request kind
        rq = ($urandom_range(0, 9) == 0) ? req_t'($urandom_range(0, 3)) : REQ_MSG;
        if (rq == REQ_INIT) rq = REQ_AD;
        send_req(rq, rnd64(), rnd64(), rnd64(), rnd64(), draw_gap());
        sent++;
      end
      send_req(REQ_FIN, rnd64(), rnd64(), rnd64(), rnd64(), draw_gap());
      sent++;
      if (sess == 20) begin
        // sender holds off until every result is back
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/rocca_pkg.sv
rtl/rocca_if.sv
rtl/rocca_ctrl.sv
rtl/rocca_dp.sv
rtl/rocca_aead_encrypt.sv
rtl/rocca_chk.sv
test/tb_top.sv
